[rtl/lerx_pkg.sv]
// Shared types and constants for the line editor receive FIFO.
// Used by every module of the block; depends on nothing.
package lerx_pkg;

  // Character codes handled by the editor.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  // Result kinds on the output channel.
  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // Commands passed from the front to the back.
  localparam logic [2:0] CMD_ECHO1   = 3'd0;  // echo one byte
  localparam logic [2:0] CMD_NEWLINE = 3'd1;  // echo CR, LF with line end
  localparam logic [2:0] CMD_RUBOUT  = 3'd2;  // echo BS, SP, BS
  localparam logic [2:0] CMD_RDATA   = 3'd3;  // popped byte
  localparam logic [2:0] CMD_EMPTY   = 3'd4;  // read on empty FIFO

  typedef struct packed {
    logic [2:0] code;
    logic [7:0] data;
  } cmd_t;

endpackage

[rtl/lerx_front.sv]
// Front of the line editor: accepts items, classifies bytes and keeps the FIFO.
// Holds the byte store and its pointers; depends on lerx_pkg.
module lerx_front #(
  parameter int FIFO_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic [1:0]          in_tuser,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output lerx_pkg::cmd_t      cmd
);

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [7:0]    mem [FIFO_DEPTH];
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [7:0]    rdata_r;
  logic          stage_valid_r, stage_valid_nxt;
  logic [2:0]    stage_code_r;
  logic [7:0]    stage_data_r;

  logic       accept, op, err, empty, full;
  logic [7:0] bn;
  logic       is_nl, is_prt, is_bs;
  logic       do_push, do_pop, do_bs, produce;
  logic [2:0] code_nxt;

  // Decode of the incoming item.
  assign op     = in_tuser[0];
  assign err    = in_tuser[1];
  assign bn     = (in_tdata == lerx_pkg::CH_CR) ? lerx_pkg::CH_LF : in_tdata;
  assign is_nl  = (bn == lerx_pkg::CH_LF);
  assign is_prt = (bn >= lerx_pkg::CH_SP) && (bn <= lerx_pkg::CH_TILDE);
  assign is_bs  = (bn == lerx_pkg::CH_BS);
  assign empty  = (fill_r == '0);
  assign full   = (fill_r == CW'(FIFO_DEPTH));

  assign in_tready = !stage_valid_r || cmd_ready;
  assign accept    = in_tvalid && in_tready;

  assign do_pop  = op && !empty;
  assign do_push = !op && !err && (is_nl || is_prt) && !full;
  assign do_bs   = !op && !err && is_bs && !empty;
  assign produce = op || (!err && (is_nl || is_prt || (is_bs && !empty)));

  always_comb begin
    if (op) begin
      code_nxt = empty ? lerx_pkg::CMD_EMPTY : lerx_pkg::CMD_RDATA;
    end else if (is_nl) begin
      code_nxt = lerx_pkg::CMD_NEWLINE;
    end else if (is_prt) begin
      code_nxt = lerx_pkg::CMD_ECHO1;
    end else begin
      code_nxt = lerx_pkg::CMD_RUBOUT;
    end
  end

  // Pointer and fill count updates.
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (accept && do_pop) begin
      head_nxt = (head_r == PW'(FIFO_DEPTH - 1)) ? '0 : head_r + PW'(1);
      fill_nxt = fill_r - CW'(1);
    end
    if (accept && do_push) begin
      tail_nxt = (tail_r == PW'(FIFO_DEPTH - 1)) ? '0 : tail_r + PW'(1);
      fill_nxt = fill_r + CW'(1);
    end
    if (accept && do_bs) begin
      tail_nxt = (tail_r == '0) ? PW'(FIFO_DEPTH - 1) : tail_r - PW'(1);
      fill_nxt = fill_r - CW'(1);
    end
  end

  // Stage register holds one command until the queue takes it.
  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (accept) begin
      stage_valid_nxt = produce;
    end else if (cmd_ready) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      tail_r        <= '0;
      fill_r        <= '0;
      stage_valid_r <= 1'b0;
    end else begin
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      fill_r        <= fill_nxt;
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_code_r <= code_nxt;
      stage_data_r <= bn;
    end
  end

  // Byte store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && do_push) begin
      mem[tail_r] <= bn;
    end
    if (accept && do_pop) begin
      rdata_r <= mem[head_r];
    end
  end

  assign cmd_valid = stage_valid_r;
  assign cmd.code  = stage_code_r;
  assign cmd.data  = (stage_code_r == lerx_pkg::CMD_RDATA) ? rdata_r : stage_data_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(FIFO_DEPTH))
    else $error("fill count beyond FIFO depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (head_r == tail_r))
    else $error("empty FIFO with mismatched pointers");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_valid_r && !cmd_ready) |=> (stage_valid_r && $stable(stage_code_r)))
    else $error("stalled command lost");
`endif

endmodule

[rtl/lerx_queue.sv]
// Two-entry command queue between the front and the back of the line editor.
// Depends on lerx_pkg for the command type.
module lerx_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  lerx_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output lerx_pkg::cmd_t pop_cmd
);

  lerx_pkg::cmd_t q [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = q[rd_r];

  // Pointer and count updates.
  always_comb begin
    wr_nxt  = do_push ? ~wr_r : wr_r;
    rd_nxt  = do_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_r] <= push_cmd;
    end
  end

endmodule

[rtl/lerx_back.sv]
// Back of the line editor: expands each command into one to three result items.
// Depends on lerx_pkg for command codes and result kinds.
module lerx_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  lerx_pkg::cmd_t cmd,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic [2:0]     out_tuser,
  output logic           out_tlast
);

  logic           cur_valid_r, cur_valid_nxt;
  lerx_pkg::cmd_t cur_r;
  logic [1:0]     step_r, step_nxt;
  logic           is_last, load;
  logic [1:0]     kind;
  logic [7:0]     data;
  logic           line_end;

  // Result fields from the current command and step.
  always_comb begin
    kind     = lerx_pkg::KIND_ECHO;
    data     = cur_r.data;
    is_last  = 1'b1;
    line_end = 1'b0;
    unique case (cur_r.code)
      lerx_pkg::CMD_ECHO1: begin
        data = cur_r.data;
      end
      lerx_pkg::CMD_NEWLINE: begin
        data     = (step_r == 2'd0) ? lerx_pkg::CH_CR : lerx_pkg::CH_LF;
        is_last  = (step_r == 2'd1);
        line_end = 1'b1;
      end
      lerx_pkg::CMD_RUBOUT: begin
        data    = (step_r == 2'd1) ? lerx_pkg::CH_SP : lerx_pkg::CH_BS;
        is_last = (step_r == 2'd2);
      end
      lerx_pkg::CMD_RDATA: begin
        kind = lerx_pkg::KIND_READ;
      end
      lerx_pkg::CMD_EMPTY: begin
        kind = lerx_pkg::KIND_EMPTY;
        data = 8'h00;
      end
      default: begin
        kind = lerx_pkg::KIND_ECHO;
      end
    endcase
  end

  assign cmd_ready = !cur_valid_r || (out_tready && is_last);
  assign load      = cmd_valid && cmd_ready;

  // Step sequencing: advance on each taken result, reload after the last one.
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    if (cmd_ready) begin
      cur_valid_nxt = cmd_valid;
      step_nxt      = 2'd0;
    end else if (out_tready) begin
      step_nxt = step_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= 2'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= cmd;
    end
  end

  assign out_tvalid = cur_valid_r;
  assign out_tdata  = data;
  assign out_tuser  = {line_end, kind};
  assign out_tlast  = is_last;

`ifndef SYNTHESIS
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (step_r <= 2'd2))
    else $error("result step out of range");

  a_single_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && (cur_r.code == lerx_pkg::CMD_RDATA ||
     cur_r.code == lerx_pkg::CMD_EMPTY || cur_r.code == lerx_pkg::CMD_ECHO1))
    |-> (step_r == 2'd0))
    else $error("single-result command past its first step");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && out_tready && !is_last) |=> (cur_valid_r && step_r != 2'd0))
    else $error("multi-result command dropped early");
`endif

endmodule

[rtl/line_editor_rx_fifo.sv]
// Top level of the serial line editor in front of a receive byte FIFO.
// Instantiates lerx_front, lerx_queue and lerx_back; depends on lerx_pkg.
//
//  Channel | Direction | tdata         | tuser (low bit up)        | tlast
//  in_     | input     | rx_byte[7:0]  | op, rx_error              | -
//  out_    | output    | data[7:0]     | kind[1:0], line_end       | last
//
// An item is taken every cycle while the command queue has room; a received
// byte produces up to three results, one per cycle while the output is ready,
// so the result sequencer in the back sets the sustained pace for rubouts.
// A popped byte comes out of the store's registered read port with its staged command.
// Reset is synchronous and active low; the byte store is not cleared.
// A stall on the output fills the queue before the input stops.
module line_editor_rx_fifo #(
  parameter int FIFO_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // rx_byte[7:0]
  input  logic [1:0] in_tuser,   // [0] op, [1] rx_error
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // data[7:0]
  output logic [2:0] out_tuser,  // [1:0] kind, [2] line_end
  output logic       out_tlast
);

  logic           f_valid, f_ready;
  lerx_pkg::cmd_t f_cmd;
  logic           b_valid, b_ready;
  lerx_pkg::cmd_t b_cmd;

  // Front: classification and FIFO storage.
  lerx_front #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  // Command queue decoupling the two halves.
  lerx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_cmd    (b_cmd)
  );

  // Back: result sequencing.
  lerx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (b_valid),
    .cmd_ready  (b_ready),
    .cmd        (b_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[tb/line_editor_rx_fifo_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the line editor receive FIFO: watches both streams, predicts
// echoes and read data per accepted item and compares them. Depends on lerx_pkg.
module line_editor_rx_fifo_checker #(
  parameter int FIFO_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // rx_byte[7:0]
  input  logic [1:0] in_tuser,   // [0] op, [1] rx_error
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // data[7:0]
  input  logic [2:0] out_tuser,  // [1:0] kind, [2] line_end
  input  logic       out_tlast,
  output int         mismatch_count,
  output int         replies_pending
);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic       line_end;
  } reply_t;

  // Shadow copy of the byte store and its pointers.
  logic [7:0]  shadow_store [FIFO_DEPTH];
  int unsigned rd_idx;
  int unsigned wr_idx;
  int unsigned held;

  reply_t pending_replies[$];

  task automatic report_mismatch(input string msg);
    begin
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
    end
  endtask

  // Edits one accepted item against the shadow store and queues its replies.
  task automatic edit_rx_item(input logic op, input logic [7:0] rx_byte,
                              input logic rx_err);
    logic [7:0] ch;
    begin
      ch = rx_byte;
      if (op) begin
        if (held > 0) begin
          pending_replies.push_back('{lerx_pkg::KIND_READ, shadow_store[rd_idx],
                                      1'b1, 1'b0});
          rd_idx = (rd_idx + 1) % FIFO_DEPTH;
          held--;
        end else begin
          pending_replies.push_back('{lerx_pkg::KIND_EMPTY, 8'h00, 1'b1, 1'b0});
        end
      end else if (!rx_err) begin
        if (ch == lerx_pkg::CH_CR) ch = lerx_pkg::CH_LF;
        if (ch == lerx_pkg::CH_LF) begin
          // A full store drops the byte, but the echo still goes out.
          if (held < FIFO_DEPTH) begin
            shadow_store[wr_idx] = ch;
            wr_idx = (wr_idx + 1) % FIFO_DEPTH;
            held++;
          end
          pending_replies.push_back('{lerx_pkg::KIND_ECHO, lerx_pkg::CH_CR, 1'b0, 1'b1});
          pending_replies.push_back('{lerx_pkg::KIND_ECHO, lerx_pkg::CH_LF, 1'b1, 1'b1});
        end else if (ch >= lerx_pkg::CH_SP && ch <= lerx_pkg::CH_TILDE) begin
          if (held < FIFO_DEPTH) begin
            shadow_store[wr_idx] = ch;
            wr_idx = (wr_idx + 1) % FIFO_DEPTH;
            held++;
          end
          pending_replies.push_back('{lerx_pkg::KIND_ECHO, ch, 1'b1, 1'b0});
        end else if (ch == lerx_pkg::CH_BS && held > 0) begin
          // Rubout takes back the newest byte still held, whatever line it is in.
          wr_idx = (wr_idx == 0) ? FIFO_DEPTH - 1 : wr_idx - 1;
          held--;
          pending_replies.push_back('{lerx_pkg::KIND_ECHO, lerx_pkg::CH_BS, 1'b0, 1'b0});
          pending_replies.push_back('{lerx_pkg::KIND_ECHO, lerx_pkg::CH_SP, 1'b0, 1'b0});
          pending_replies.push_back('{lerx_pkg::KIND_ECHO, lerx_pkg::CH_BS, 1'b1, 1'b0});
        end
      end
    end
  endtask

  // Predict on accepted inputs first, then compare accepted results in order.
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      rd_idx = 0;
      wr_idx = 0;
      held   = 0;
      pending_replies.delete();
    end else begin
      if (in_tvalid && in_tready)
        edit_rx_item(in_tuser[0], in_tdata, in_tuser[1]);
      if (out_tvalid && out_tready) begin
        if (pending_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0d data=%02h last=%0b le=%0b",
                                    out_tuser[1:0], out_tdata, out_tlast, out_tuser[2]));
        end else begin
          want = pending_replies.pop_front();
          if (out_tuser[1:0] !== want.kind || out_tdata !== want.data ||
              out_tlast !== want.last || out_tuser[2] !== want.line_end)
            report_mismatch($sformatf(
              "got kind=%0d data=%02h last=%0b le=%0b, want kind=%0d data=%02h last=%0b le=%0b",
              out_tuser[1:0], out_tdata, out_tlast, out_tuser[2],
              want.kind, want.data, want.last, want.line_end));
        end
      end
    end
    replies_pending <= pending_replies.size();
  end

endmodule

[tb/line_editor_rx_fifo_tb.sv]
`timescale 1ns / 1ps
// Top of the line editor receive FIFO testbench: clock, reset, stimulus and
// verdict. Depends on line_editor_rx_fifo, line_editor_rx_fifo_checker, lerx_pkg.
module line_editor_rx_fifo_tb;

  localparam int FIFO_DEPTH   = 128;
  localparam int TARGET_ITEMS = 410;
  localparam int HOLD_CYCLES  = 300;

  // Values of the op field.
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // rx_byte[7:0]
  logic [1:0] in_tuser;   // [0] op, [1] rx_error
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // data[7:0]
  logic [2:0] out_tuser;  // [1:0] kind, [2] line_end
  logic       out_tlast;

  int mismatch_count;
  int replies_pending;
  int sent_items;
  bit no_idle;
  bit hold_request;
  int hold_left;

  line_editor_rx_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  line_editor_rx_fifo_checker #(.FIFO_DEPTH(FIFO_DEPTH)) i_scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .mismatch_count  (mismatch_count),
    .replies_pending (replies_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Safety net against a hung handshake.
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    out_tready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 34);
      end
    end
  end

  // Offers one item, with random idle cycles ahead of it unless no_idle is set; waits for acceptance.
  task automatic send_item(input logic op, input logic [7:0] rx_byte, input logic rx_err);
    begin
      if (!no_idle) begin
        while ($urandom_range(0, 99) < 34) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
        end
      end
      in_tvalid <= 1'b1;
      in_tdata  <= rx_byte;
      in_tuser  <= {rx_err, op};
      do @(posedge clk); while (!in_tready);
      sent_items++;
    end
  endtask

  // Stops offering until every expected result has been taken.
  task automatic wait_replies_done();
    begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while (replies_pending != 0);
    end
  endtask

  // One item drawn from all classes; read_pct sets the share of read requests.
  task automatic send_random_item(input int read_pct);
    int         pick;
    logic [7:0] b;
    begin
      if ($urandom_range(0, 99) < read_pct) begin
        send_item(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          send_item(OP_RX, 8'($urandom_range(lerx_pkg::CH_SP, lerx_pkg::CH_TILDE)), 1'b0);
        end else if (pick < 55) begin
          send_item(OP_RX, $urandom_range(0, 1) ? lerx_pkg::CH_CR : lerx_pkg::CH_LF, 1'b0);
        end else if (pick < 72) begin
          send_item(OP_RX, lerx_pkg::CH_BS, 1'b0);
        end else if (pick < 80) begin
          send_item(OP_RX, 8'($urandom_range(0, 255)), 1'b1);
        end else if (pick < 90) begin
          // Ignored bytes: high codes or control codes the editor has no use for.
          if ($urandom_range(0, 1)) begin
            b = 8'($urandom_range(8'h7F, 8'hFF));
          end else begin
            do b = 8'($urandom_range(0, 31));
            while (b == lerx_pkg::CH_CR || b == lerx_pkg::CH_LF || b == lerx_pkg::CH_BS);
          end
          send_item(OP_RX, b, 1'b0);
        end else begin
          send_item(OP_RX, 8'($urandom_range(0, 255)), 1'b0);
        end
      end
    end
  endtask

  // A typed line: printable text with occasional rubouts, closed by CR or LF.
  task automatic send_line();
    int len;
    begin
      len = $urandom_range(1, 12);
      repeat (len) begin
        if ($urandom_range(0, 99) < 12) begin
          send_item(OP_RX, lerx_pkg::CH_BS, 1'b0);
        end else begin
          send_item(OP_RX, 8'($urandom_range(lerx_pkg::CH_SP, lerx_pkg::CH_TILDE)), 1'b0);
        end
      end
      send_item(OP_RX, $urandom_range(0, 1) ? lerx_pkg::CH_CR : lerx_pkg::CH_LF, 1'b0);
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= 8'h00;
    in_tuser     <= 2'b00;
    sent_items   = 0;
    no_idle      = 1'b0;
    hold_request = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty read, rubout on empty, errored, printable and ignored bytes, line ends, rubout.
    send_item(OP_READ, 8'h00, 1'b0);
    send_item(OP_RX, lerx_pkg::CH_BS, 1'b0);
    send_item(OP_RX, 8'h41, 1'b1);
    send_item(OP_RX, 8'hFF, 1'b1);
    send_item(OP_RX, lerx_pkg::CH_SP, 1'b0);
    send_item(OP_RX, lerx_pkg::CH_TILDE, 1'b0);
    send_item(OP_RX, 8'h41, 1'b0);
    send_item(OP_RX, 8'h00, 1'b0);
    send_item(OP_RX, 8'h1F, 1'b0);
    send_item(OP_RX, 8'h7F, 1'b0);
    send_item(OP_RX, 8'h80, 1'b0);
    send_item(OP_RX, 8'hFF, 1'b0);
    send_item(OP_RX, lerx_pkg::CH_CR, 1'b0);
    send_item(OP_RX, lerx_pkg::CH_LF, 1'b0);
    send_item(OP_RX, lerx_pkg::CH_BS, 1'b0);
    // Drain the store, ending with a read on empty.
    send_item(OP_READ, 8'hFF, 1'b1);
    send_item(OP_READ, 8'h00, 1'b0);
    send_item(OP_READ, 8'hA5, 1'b1);
    send_item(OP_READ, 8'h5A, 1'b0);
    send_item(OP_READ, 8'h00, 1'b0);
    // Rubout after a read takes back the newline of the earlier line.
    send_item(OP_RX, 8'h61, 1'b0);
    send_item(OP_RX, 8'h62, 1'b0);
    send_item(OP_RX, lerx_pkg::CH_CR, 1'b0);
    send_item(OP_READ, 8'h00, 1'b0);
    send_item(OP_RX, lerx_pkg::CH_BS, 1'b0);

    // Random mix at full rate on both sides.
    no_idle = 1'b1;
    repeat (50) begin
      if ($urandom_range(0, 99) < 50) send_line();
      else send_random_item(30);
    end
    no_idle = 1'b0;
    wait_replies_done();

    // Receiver holds off while the store is filled past its depth.
    hold_request = 1'b1;
    repeat (FIFO_DEPTH + 7) begin
      send_item(OP_RX, 8'($urandom_range(lerx_pkg::CH_SP, lerx_pkg::CH_TILDE)), 1'b0);
    end
    send_item(OP_RX, lerx_pkg::CH_LF, 1'b0);
    send_item(OP_RX, lerx_pkg::CH_CR, 1'b0);
    send_item(OP_RX, lerx_pkg::CH_BS, 1'b0);

    // Read-heavy random mix until the item budget is spent.
    while (sent_items < TARGET_ITEMS) begin
      if ($urandom_range(0, 99) < 30) send_line();
      else send_random_item(55);
    end

    wait_replies_done();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && replies_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
